### src/udp_pchk_pkg.sv
package udp_pchk_pkg;

  // Protocol number of UDP, added into the pseudo header.
  localparam logic [15:0] PROTO_UDP = 16'd17;

  // One classified item, as it waits between the front and the back.
  typedef struct packed {
    logic [15:0] word;   // value to add into the running sum, zero if left out
    logic [15:0] phdr;   // folded pseudo header sum, meaningful only with last
    logic        last;
  } item_t;

endpackage

### src/udp_pseudo_header_checksum.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  data_word, odd_tail, last, source/destination address
// out_     output     out_valid/out_stall checksum, one item per segment
//
// One word is taken every cycle while the two-entry queue has room; in_stall
// is high only when that queue is full. Once its last word has left the queue
// and the output register is free, a checksum is registered there and sits in
// that register until taken. Reset is synchronous and clears segment state,
// queue and output.
module udp_pseudo_header_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_data_word,
  input  logic        in_odd_tail,
  input  logic        in_last,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_destination_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum
);

  udp_pchk_pkg::item_t front_item;
  udp_pchk_pkg::item_t head;
  logic                q_full;
  logic                head_valid;
  logic                pop;
  logic                accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  udp_pchk_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .data_word           (in_data_word),
    .odd_tail            (in_odd_tail),
    .last                (in_last),
    .source_address      (in_source_address),
    .destination_address (in_destination_address),
    .item                (front_item)
  );

  udp_pchk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  udp_pchk_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

endmodule

### src/udp_pchk_front.sv
module udp_pchk_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [15:0]         data_word,
  input  logic                odd_tail,
  input  logic                last,
  input  logic [31:0]         source_address,
  input  logic [31:0]         destination_address,
  output udp_pchk_pkg::item_t item
);

  localparam logic [1:0] PosLength   = 2'd2;
  localparam logic [1:0] PosChecksum = 2'd3;

  logic [1:0]  pos_r, pos_nxt;
  logic        skipped_r, skipped_nxt;
  logic [15:0] len_r, len_nxt;

  logic [15:0] word_m;
  logic [15:0] len_use;
  logic        skip;
  logic [18:0] phdr_wide;
  logic [16:0] phdr_f1;
  logic [15:0] phdr_f2;

  always_comb begin
    word_m  = odd_tail ? {data_word[15:8], 8'h00} : data_word;
    len_use = (pos_r == PosLength) ? word_m : len_r;
    skip    = (pos_r == PosChecksum) && !skipped_r;

    phdr_wide = {3'b000, len_use}
              + {3'b000, source_address[31:16]} + {3'b000, source_address[15:0]}
              + {3'b000, destination_address[31:16]}
              + {3'b000, destination_address[15:0]}
              + {3'b000, udp_pchk_pkg::PROTO_UDP};
    // Two folds are enough: the first leaves at most one carry.
    phdr_f1 = {1'b0, phdr_wide[15:0]} + {14'd0, phdr_wide[18:16]};
    phdr_f2 = phdr_f1[15:0] + {15'd0, phdr_f1[16]};

    item.word = skip ? 16'h0000 : word_m;
    item.phdr = phdr_f2;
    item.last = last;

    pos_nxt     = pos_r;
    skipped_nxt = skipped_r;
    len_nxt     = len_r;
    if (accept) begin
      if (last) begin
        pos_nxt     = 2'd0;
        skipped_nxt = 1'b0;
        len_nxt     = 16'h0000;
      end else begin
        if (pos_r != PosChecksum) begin
          pos_nxt = pos_r + 2'd1;
        end
        if (skip) begin
          skipped_nxt = 1'b1;
        end
        len_nxt = len_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 2'd0;
      skipped_r <= 1'b0;
      len_r     <= 16'h0000;
    end else begin
      pos_r     <= pos_nxt;
      skipped_r <= skipped_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

### src/udp_pchk_queue.sv
module udp_pchk_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  udp_pchk_pkg::item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output udp_pchk_pkg::item_t head
);

  localparam int Depth = 2;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  udp_pchk_pkg::item_t slot_r [Depth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == FullCnt);
    head_valid = (count_r != '0);
    head       = slot_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/udp_pchk_back.sv
module udp_pchk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  udp_pchk_pkg::item_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_checksum
);

  logic [15:0] acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_checksum_r, out_checksum_nxt;

  logic [16:0] sum1_w, fin_w;
  logic [15:0] sum1, fin;
  logic        can_emit;

  // Ones' complement add of two 16-bit values with the end-around carry.
  // A sum is zero only when both operands are zero.
  always_comb begin
    sum1_w = {1'b0, acc_r} + {1'b0, head.word};
    sum1   = sum1_w[15:0] + {15'd0, sum1_w[16]};
    fin_w  = {1'b0, sum1} + {1'b0, head.phdr};
    fin    = fin_w[15:0] + {15'd0, fin_w[16]};

    can_emit = !out_valid_r || !out_stall;
    pop      = head_valid && (!head.last || can_emit);

    acc_nxt          = acc_r;
    out_checksum_nxt = out_checksum_r;
    out_valid_nxt    = out_valid_r && out_stall;
    if (pop) begin
      if (head.last) begin
        acc_nxt          = 16'h0000;
        out_checksum_nxt = ~fin;
        out_valid_nxt    = 1'b1;
      end else begin
        acc_nxt = sum1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_checksum_r <= out_checksum_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

endmodule

### bench/testbench.sv
module testbench;

  // Predicts the UDP checksum one segment word at a time and holds the
  // checksums that the block still owes.
  class checksum_scoreboard;
    logic [31:0] sum;
    logic [1:0]  position;
    logic [15:0] length;
    bit          skipped;
    logic [15:0] expected_sums[$];
    int          fail_count;

    function new();
      clear_segment();
      fail_count = 0;
    endfunction

    function void clear_segment();
      sum      = '0;
      position = '0;
      length   = '0;
      skipped  = 1'b0;
    endfunction

    // Ones' complement add on 32 bits: a carry out of bit 31 goes back into bit 0.
    function logic [31:0] add_wrap(logic [31:0] a, logic [31:0] b);
      logic [32:0] t;
      t = {1'b0, a} + {1'b0, b};
      t = {1'b0, t[31:0]} + {32'b0, t[32]};
      return t[31:0] + {31'b0, t[32]};
    endfunction

    function void note_word(logic [15:0] data, logic odd, logic last,
                            logic [31:0] src, logic [31:0] dst);
      logic [15:0] w;
      logic [31:0] s;
      w = odd ? {data[15:8], 8'h00} : data;
      if (position == 2'd2) length = w;
      // The first word at index three is the checksum field and is not summed.
      if (position == 2'd3 && !skipped) skipped = 1'b1;
      else sum = add_wrap(sum, {16'b0, w});
      if (position != 2'd3) position = position + 2'd1;
      if (last) begin
        s = sum;
        s = add_wrap(s, {16'b0, src[31:16]} + {16'b0, src[15:0]});
        s = add_wrap(s, {16'b0, dst[31:16]} + {16'b0, dst[15:0]});
        s = add_wrap(s, {16'b0, length});
        s = add_wrap(s, {16'b0, udp_pchk_pkg::PROTO_UDP});
        while (s[31:16] != 16'b0) s = {16'b0, s[31:16]} + {16'b0, s[15:0]};
        expected_sums.push_back(~s[15:0]);
        clear_segment();
      end
    endfunction

    function void check_checksum(logic [15:0] actual);
      logic [15:0] want;
      if (expected_sums.size() == 0) begin
        $display("%0t: checksum %h arrived with none expected", $time, actual);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        if (actual !== want) begin
          $display("%0t: checksum expected %h actual %h", $time, want, actual);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_data_word;
  logic        in_odd_tail;
  logic        in_last;
  logic [31:0] in_source_address;
  logic [31:0] in_destination_address;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_checksum;

  checksum_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  int words_sent;

  udp_pseudo_header_checksum dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_word           (in_data_word),
    .in_odd_tail            (in_odd_tail),
    .in_last                (in_last),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_checksum           (out_checksum)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_checksum(out_checksum);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(logic [15:0] data, logic odd, logic last,
                           logic [31:0] src, logic [31:0] dst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_data_word           <= data;
    in_odd_tail            <= odd;
    in_last                <= last;
    in_source_address      <= src;
    in_destination_address <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(data, odd, last, src, dst);
    words_sent++;
  endtask

  task automatic wait_for_checksums();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_sums.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_address();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A well formed header with a random payload; now and then a wrong length,
  // an odd byte inside the payload, or a segment cut short before the header ends.
  task automatic random_segment();
    int          n;
    bit          odd_end;
    logic [15:0] w;
    logic [31:0] src;
    logic [31:0] dst;
    case ($urandom_range(9))
      0:       n = $urandom_range(3, 1);
      1:       n = $urandom_range(80, 25);
      default: n = $urandom_range(24, 4);
    endcase
    odd_end = ($urandom_range(9) < 3);
    src = pick_address();
    dst = pick_address();
    for (int i = 0; i < n; i++) begin
      w = $urandom();
      if (i == 2 && $urandom_range(9) < 7) w = 16'(2 * n - (odd_end ? 1 : 0));
      if (i == n - 1)
        send_word(w, odd_end, 1'b1, src, dst);
      else
        send_word(w, ($urandom_range(99) < 3), 1'b0, $urandom(), $urandom());
    end
  endtask

  initial begin
    int idle_set[4]  = '{0, 45, 0, 12};
    int stall_set[4] = '{0, 0, 45, 12};
    int target;
    int guard;
    rst_n                  <= 1'b0;
    in_valid               <= 1'b0;
    in_data_word           <= '0;
    in_odd_tail            <= 1'b0;
    in_last                <= 1'b0;
    in_source_address      <= '0;
    in_destination_address <= '0;
    idle_pct   = 0;
    stall_pct  = 0;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single word that sums to all ones, so the checksum comes out as zero.
    send_word(16'hFFEE, 1'b0, 1'b1, 32'h0, 32'h0);
    send_word(16'h0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(16'hFFFF, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'hFFFF, 1'b1, 1'b1, 32'hC0A8_0001, 32'h0A00_0002);
    // Last word at index two also serves as the length.
    send_word(16'h1234, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'h5678, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'hFFFF, 1'b0, 1'b1, 32'h7F00_0001, 32'hFFFF_FFFF);
    send_word(16'h04D2, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'h0035, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'h0008, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'hABCD, 1'b0, 1'b1, 32'h0101_0101, 32'h0202_0202);
    // Odd byte flag inside the payload as well as on the last word.
    send_word(16'h0400, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'h0401, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'h000D, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'hFFFF, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'hAAFF, 1'b1, 1'b0, 32'h0, 32'h0);
    send_word(16'h55AA, 1'b0, 1'b0, 32'h0, 32'h0);
    send_word(16'h80FF, 1'b1, 1'b1, 32'hFFFF_0000, 32'h0000_FFFF);
    for (int i = 0; i < 6; i++)
      send_word(16'hFFFF, 1'b0, i == 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_for_checksums();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      target = words_sent + 475;
      while (words_sent < target) random_segment();
      wait_for_checksums();
    end

    in_valid <= 1'b0;
    guard = 0;
    while (sb.expected_sums.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.expected_sums.size() != 0)
      $display("%0t: %0d checksums never arrived, next expected %h", $time,
               sb.expected_sums.size(), sb.expected_sums[0]);
    if (sb.fail_count == 0 && sb.expected_sums.size() == 0) begin
      $display("PASS udp_pseudo_header_checksum");
    end else begin
      $display("FAIL udp_pseudo_header_checksum");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("FAIL udp_pseudo_header_checksum");
    $finish;
  end

endmodule

### sim.f
src/udp_pchk_pkg.sv
src/udp_pchk_front.sv
src/udp_pchk_queue.sv
src/udp_pchk_back.sv
src/udp_pseudo_header_checksum.sv
bench/testbench.sv
